/* rtl/bcd_pkg.sv */
// Package: shared types and constants for the button click discriminator.
`timescale 1ns / 1ps

package bcd_pkg;

   localparam int NOW_WIDTH       = 32;
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd40;
   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd350;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEBOUNCE = 1'b0,
      REG_WINDOW   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_DOUBLE  = 2'd1,
      EV_SINGLE  = 2'd2,
      EV_DROPPED = 2'd3
   } click_event_type;

   typedef struct packed {
      logic                 down;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 busy;
   } sample_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] double_click_window;
   } cfg_type;

endpackage

/* rtl/bcd_if.sv */
// Interfaces: request and response channels.
`timescale 1ns / 1ps

interface bcd_req_if;
   logic        valid;
   logic        ready;
   logic        pilot_button;
   logic        observer_button;
   logic [31:0] now_ms;
   logic        playback_busy;

   modport source (output valid, pilot_button, observer_button, now_ms, playback_busy,
                   input ready);
   modport sink   (input valid, pilot_button, observer_button, now_ms, playback_busy,
                   output ready);
endinterface

interface bcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] click_event;

   modport source (output valid, click_event, input ready);
   modport sink   (input valid, click_event, output ready);
endinterface

/* rtl/bcd_in_stage.sv */
// Input register stage: holds one sampled item until the decision stage takes it.
`timescale 1ns / 1ps

module bcd_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               advance,
   input  bcd_pkg::sample_type sample_d,
   output logic               stage_valid,
   output bcd_pkg::sample_type sample_q
);
   import bcd_pkg::*;

   logic       valid_ff, valid_in;
   sample_type sample_ff;

   assign valid_in = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_d;
      end
   end

   assign stage_valid = valid_ff;
   assign sample_q    = sample_ff;

endmodule

/* rtl/bcd_click_fsm.sv */
// Click state and event decision: debounce, double-click window, expiry.
`timescale 1ns / 1ps

module bcd_click_fsm #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  bcd_pkg::sample_type     sample,
   input  bcd_pkg::cfg_type        cfg,
   output bcd_pkg::click_event_type click_event
);
   import bcd_pkg::*;

   logic                  prev_level_ff, prev_level_in;
   logic [TIME_WIDTH-1:0] last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0] first_click_ff, first_click_in;
   logic                  pending_ff, pending_in;

   logic [TIME_WIDTH-1:0] now_t, since_edge, since_first;
   logic                  edge_ok, press_ok, release_ok, in_window;
   click_event_type       ev;

   // timestamp reduced (or widened) to the time width, differences wrap
   assign now_t       = TIME_WIDTH'(sample.now_ms);
   assign since_edge  = now_t - last_edge_ff;
   assign since_first = now_t - first_click_ff;
   assign edge_ok     = since_edge > TIME_WIDTH'(cfg.debounce_time);
   assign in_window   = since_first <= TIME_WIDTH'(cfg.double_click_window);
   assign press_ok    = sample.down & ~prev_level_ff & edge_ok;
   assign release_ok  = ~sample.down & prev_level_ff & edge_ok;

   always_comb begin
      prev_level_in  = sample.down;
      last_edge_in   = last_edge_ff;
      first_click_in = first_click_ff;
      pending_in     = pending_ff;
      ev             = EV_NONE;
      if (press_ok | release_ok) begin
         last_edge_in = now_t;
      end
      if (press_ok) begin
         if (pending_ff & in_window) begin
            pending_in = 1'b0;
            ev         = EV_DOUBLE;
         end else begin
            // new first click; a stale pending one is dropped silently
            pending_in     = 1'b1;
            first_click_in = now_t;
         end
      end else if (pending_ff & ~in_window) begin
         pending_in = 1'b0;
         ev         = sample.busy ? EV_DROPPED : EV_SINGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff  <= 1'b0;
         last_edge_ff   <= '0;
         first_click_ff <= '0;
         pending_ff     <= 1'b0;
      end else if (step) begin
         prev_level_ff  <= prev_level_in;
         last_edge_ff   <= last_edge_in;
         first_click_ff <= first_click_in;
         pending_ff     <= pending_in;
      end
   end

   assign click_event = ev;

   a_event_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (step && ev != EV_NONE) |=> !pending_ff)
      else $error("pending click survived a reported event");

   a_event_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (step && ev != EV_NONE) |-> pending_ff)
      else $error("event reported with no pending click");

   a_press_sets_edge: assert property (@(posedge clock) disable iff (reset)
      (step && press_ok) |=> (last_edge_ff == $past(now_t)))
      else $error("accepted press did not refresh edge time");

endmodule

/* rtl/button_click_discriminator_core.sv */
// Top level: button click discriminator with input stage, decision and result register.
//
//  channel  | direction | payload                                         | handshake
//  ---------+-----------+-------------------------------------------------+------------
//  req_ch   | in        | pilot_button, observer_button, now_ms, busy     | valid/ready
//  rsp_ch   | out       | click_event (0 none,1 double,2 single,3 dropped)| valid/ready
//  csr_*    | in        | debounce_time, double_click_window (16b each)   | write enable
//
//  One item per cycle unless rsp_ch stalls; rsp valid comes from the result register.
//  The rate is set by the single state-update path (subtract and compare on
//  the time width) between the input register and the result register.
//  Reset (synchronous, active high) clears state and loads the default
//  debounce time (40) and window (350). A stalled response holds the
//  result register; the input register still takes an item while it is empty.
`timescale 1ns / 1ps

module button_click_discriminator_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bcd_req_if.sink                               req_ch,
   bcd_rsp_if.source                             rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [bcd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bcd_pkg::CFG_WIDTH-1:0]         csr_wdata
);
   import bcd_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time       <= DEBOUNCE_RESET;
         cfg_ff.double_click_window <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_DEBOUNCE: cfg_ff.debounce_time       <= csr_wdata;
            REG_WINDOW:   cfg_ff.double_click_window <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control: stage 1 moves into the result register when that
   // register is empty or being drained this cycle
   logic            s1_valid, s1_move, req_take;
   logic            out_valid_ff, out_valid_in;
   click_event_type out_event_ff, step_event;
   sample_type      sample_d, sample_q;

   assign s1_move  = s1_valid & (~out_valid_ff | rsp_ch.ready);
   assign req_take = req_ch.valid & req_ch.ready;
   assign req_ch.ready = ~s1_valid | s1_move;

   assign sample_d.down   = req_ch.pilot_button | req_ch.observer_button;
   assign sample_d.now_ms = req_ch.now_ms;
   assign sample_d.busy   = req_ch.playback_busy;

   bcd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (req_take),
      .advance     (s1_move),
      .sample_d    (sample_d),
      .stage_valid (s1_valid),
      .sample_q    (sample_q)
   );

   bcd_click_fsm #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_click_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_move),
      .sample      (sample_q),
      .cfg         (cfg_ff),
      .click_event (step_event)
   );

   // result register
   assign out_valid_in = s1_move | (out_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_event_ff <= step_event;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.click_event = out_event_ff;

   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid)
      else $error("accepted item not held in input stage");

   a_move_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> out_valid_ff)
      else $error("stepped item missing from result register");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && !s1_move) |=> (s1_valid && $stable(sample_q)))
      else $error("input stage lost a blocked item");

endmodule

/* verif/tb_top.sv */
// Testbench: click discriminator checked item by item against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
   import bcd_pkg::*;

   // One button sample as offered on the request channel.
   typedef struct packed {
      logic                 pilot;
      logic                 observer;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 busy;
   } sample_item_type;

   localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
   localparam int IDLE_PCT    = 11;     // percent of cycles each side sits out
   localparam int PHASE_ITEMS = 260;    // random items per configuration phase

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcd_req_if req_ch ();
   bcd_rsp_if rsp_ch ();

   // Every block input gets a known value from time zero.
   logic                 drv_valid    = 1'b0;
   logic                 drv_pilot    = 1'b0;
   logic                 drv_observer = 1'b0;
   logic [NOW_WIDTH-1:0] drv_now      = '0;
   logic                 drv_busy     = 1'b0;
   logic                 drv_ready    = 1'b0;

   logic                 csr_write_enable = 1'b0;
   csr_index_type        csr_index        = REG_DEBOUNCE;
   logic [CFG_WIDTH-1:0] csr_wdata        = '0;

   assign req_ch.valid           = drv_valid;
   assign req_ch.pilot_button    = drv_pilot;
   assign req_ch.observer_button = drv_observer;
   assign req_ch.now_ms          = drv_now;
   assign req_ch.playback_busy   = drv_busy;
   assign rsp_ch.ready           = drv_ready;

   button_click_discriminator_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor state: our own copy of the button tracker and registers.
   // ------------------------------------------------------------------
   logic                 btn_level      = 1'b0;
   logic [NOW_WIDTH-1:0] last_edge_ms   = '0;
   logic [NOW_WIDTH-1:0] first_click_ms = '0;
   logic                 click_waiting  = 1'b0;
   logic [CFG_WIDTH-1:0] cfg_debounce   = DEBOUNCE_RESET;
   logic [CFG_WIDTH-1:0] cfg_window     = WINDOW_RESET;

   sample_item_type pending_samples[$];   // items not yet offered
   click_event_type expected_events[$];   // predicted results, oldest first

   int  req_sent     = 0;   // items put on the request channel
   int  req_accepted = 0;   // items the block has taken
   int  quiet_cycles = 0;
   int  errors       = 0;
   bit  steady       = 1'b0;  // no idling on either side while set

   // Generator's view of the registers and its running timestamp.
   logic [NOW_WIDTH-1:0] stamp_ms   = '0;
   logic [NOW_WIDTH-1:0] gen_deb    = DEBOUNCE_RESET;
   logic [NOW_WIDTH-1:0] gen_window = WINDOW_RESET;

   // Advances the tracker by one sample and returns the click it reports.
   // All time differences are taken modulo 2^32 by the vector width.
   function automatic click_event_type classify_click(input logic down,
                                                      input logic [NOW_WIDTH-1:0] now,
                                                      input logic busy);
      click_event_type      outcome;
      logic [NOW_WIDTH-1:0] since_edge;
      logic [NOW_WIDTH-1:0] since_click;
      logic                 edge_ok;
      outcome    = EV_NONE;
      since_edge = now - last_edge_ms;
      edge_ok    = since_edge > NOW_WIDTH'(cfg_debounce);
      if (down && !btn_level && edge_ok) begin
         last_edge_ms = now;
         since_click  = now - first_click_ms;
         if (click_waiting && since_click <= NOW_WIDTH'(cfg_window)) begin
            click_waiting = 1'b0;
            outcome       = EV_DOUBLE;
         end else begin
            // also covers a stale click whose window ran out unreported
            click_waiting  = 1'b1;
            first_click_ms = now;
         end
      end
      if (!down && btn_level && edge_ok) begin
         last_edge_ms = now;
      end
      // level follows the sample even when the edge was rejected
      btn_level   = down;
      since_click = now - first_click_ms;
      if (click_waiting && since_click > NOW_WIDTH'(cfg_window)) begin
         click_waiting = 1'b0;
         outcome       = busy ? EV_DROPPED : EV_SINGLE;
      end
      return outcome;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: inputs change on the falling edge. A new item goes
   // out only once the previous one has been taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      sample_item_type s;
      if (!reset && (!drv_valid || req_accepted == req_sent)) begin
         if (pending_samples.size() != 0 &&
             (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            s = pending_samples.pop_front();
            drv_pilot    <= s.pilot;
            drv_observer <= s.observer;
            drv_now      <= s.now_ms;
            drv_busy     <= s.busy;
            drv_valid    <= 1'b1;
            req_sent     <= req_sent + 1;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         drv_ready <= 1'b0;
      end else begin
         drv_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge. Register writes
   // update the predictor's copy; accepted items are predicted; accepted
   // results are compared with the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      click_event_type want;
      bit              moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               REG_DEBOUNCE: cfg_debounce = csr_wdata;
               REG_WINDOW:   cfg_window   = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_events.push_back(classify_click(
               req_ch.pilot_button | req_ch.observer_button,
               req_ch.now_ms, req_ch.playback_busy));
            req_accepted <= req_accepted + 1;
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (expected_events.size() == 0) begin
               $display("%0t: click_event extra result, expected none actual %0d",
                        $time, rsp_ch.click_event);
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_ch.click_event !== want) begin
                  $display("%0t: click_event mismatch, expected %0d actual %0d",
                           $time, want, rsp_ch.click_event);
                  errors++;
               end
            end
         end
         // watchdog on handshake activity
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Queue one sample dt ms after the previous one; a press picks the
   // pilot button, the observer button or both.
   task automatic push_sample(input logic down, input logic [NOW_WIDTH-1:0] dt,
                              input logic busy);
      sample_item_type s;
      int              who;
      stamp_ms   = stamp_ms + dt;
      who        = $urandom_range(0, 2);
      s.pilot    = down && (who != 1);
      s.observer = down && (who != 0);
      s.now_ms   = stamp_ms;
      s.busy     = busy;
      pending_samples.push_back(s);
   endtask

   task automatic push_at(input logic down, input logic [NOW_WIDTH-1:0] t,
                          input logic busy);
      push_sample(down, t - stamp_ms, busy);
   endtask

   function automatic logic rand_busy();
      return $urandom_range(0, 2) == 0;
   endfunction

   // A gap that lands on, just around, anywhere below, or somewhat past a time limit.
   function automatic logic [NOW_WIDTH-1:0] near_limit(input logic [NOW_WIDTH-1:0] lim);
      case ($urandom_range(0, 5))
         0: return lim;
         1: return lim + 1;
         2: return (lim == 0) ? lim : lim - 1;
         3: return $urandom_range(0, lim);
         4: return lim + $urandom_range(1, 300);
         default: return lim + 1 + $urandom_range(0, 30);
      endcase
   endfunction

   // One button gesture: mostly clean single and double clicks with random
   // timing around the limits, plus bounce, wild time jumps and idle time.
   task automatic add_gesture();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // single click, then idle near or past the window
            push_sample(1'b1, gen_deb + 1 + $urandom_range(0, 20), rand_busy());
            push_sample(1'b0, near_limit(gen_deb), rand_busy());
            n = $urandom_range(1, 3);
            repeat (n) push_sample(1'b0, near_limit(gen_window), rand_busy());
         end
         4, 5, 6: begin
            // press, release, press again inside or around the window
            push_sample(1'b1, gen_deb + 1 + $urandom_range(0, 20), rand_busy());
            push_sample(1'b0, gen_deb + 1 + $urandom_range(0, 20), rand_busy());
            if ($urandom_range(0, 1) == 0)
               push_sample(1'b1, near_limit(gen_deb), rand_busy());
            else
               push_sample(1'b1, near_limit(gen_window / 2), rand_busy());
            push_sample(1'b0, near_limit(gen_deb), rand_busy());
         end
         7: begin
            // contact bounce inside the debounce time
            n = $urandom_range(2, 6);
            repeat (n) push_sample(1'($urandom_range(0, 1)), $urandom_range(0, gen_deb),
                                   rand_busy());
         end
         8: begin
            // arbitrary levels and timestamps, including backward jumps
            n = $urandom_range(1, 4);
            repeat (n) push_sample(1'($urandom_range(0, 1)), $urandom(),
                                   1'($urandom_range(0, 1)));
         end
         default: begin
            n = $urandom_range(1, 4);
            repeat (n) push_sample(1'b0, $urandom_range(0, gen_window + 10), rand_busy());
         end
      endcase
   endtask

   task automatic fill_random_phase();
      while (pending_samples.size() < PHASE_ITEMS) add_gesture();
   endtask

   // Wait until every queued item is taken and every result has come, then
   // let the input and result registers settle.
   task automatic drain();
      while (pending_samples.size() != 0 || req_accepted != req_sent ||
             expected_events.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_regs(input logic [CFG_WIDTH-1:0] deb,
                             input logic [CFG_WIDTH-1:0] win);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_DEBOUNCE;
      csr_wdata        <= deb;
      @(negedge clock);
      csr_index        <= REG_WINDOW;
      csr_wdata        <= win;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      gen_deb    = NOW_WIDTH'(deb);
      gen_window = NOW_WIDTH'(win);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings (debounce 40, window 350).
      push_at(1'b1, 32'd10, 1'b0);          // press too early: rejected
      push_at(1'b0, 32'd20, 1'b0);          // release rejected too
      push_at(1'b1, 32'd41, 1'b0);          // first click
      push_at(1'b0, 32'd81, 1'b1);          // exactly the debounce: rejected
      push_at(1'b1, 32'd82, 1'b0);          // second press: double click
      push_at(1'b0, 32'd123, 1'b0);
      push_at(1'b1, 32'd500, 1'b1);         // first click
      push_at(1'b0, 32'd541, 1'b0);
      push_at(1'b0, 32'd850, 1'b0);         // exactly the window: still waiting
      push_at(1'b0, 32'd851, 1'b0);         // single click
      push_at(1'b1, 32'd1300, 1'b0);
      push_at(1'b0, 32'd1400, 1'b0);
      push_at(1'b0, 32'd1651, 1'b1);        // expires while busy: dropped
      push_at(1'b1, 32'd2000, 1'b0);
      push_at(1'b0, 32'd2100, 1'b0);
      push_at(1'b1, 32'd2400, 1'b0);        // stale pending click replaced silently
      push_at(1'b0, 32'd2500, 1'b0);
      push_at(1'b0, 32'hFFFF_FF00, 1'b0);   // old click commits
      push_at(1'b1, 32'hFFFF_FFF0, 1'b1);   // click just before the wrap
      push_at(1'b0, 32'h0000_0020, 1'b0);
      push_at(1'b1, 32'h0000_0050, 1'b0);   // double click across the wrap
      push_at(1'b0, 32'hFFFF_FFFF, 1'b1);   // time runs backward
      push_at(1'b0, 32'h0000_0000, 1'b1);
      drain();

      fill_random_phase();
      drain();

      // Extremes and a random setting for both registers.
      write_regs(16'd0, 16'd0);
      fill_random_phase();
      drain();

      write_regs(16'hFFFF, 16'hFFFF);
      fill_random_phase();
      drain();

      write_regs(16'd0, 16'hFFFF);
      fill_random_phase();
      drain();

      write_regs(16'hFFFF, 16'd0);
      fill_random_phase();
      drain();

      write_regs(CFG_WIDTH'($urandom_range(1, 200)), CFG_WIDTH'($urandom_range(1, 1000)));
      fill_random_phase();
      drain();

      // Back to the defaults, full throughput with no idling anywhere.
      write_regs(DEBOUNCE_RESET, WINDOW_RESET);
      steady = 1'b1;
      fill_random_phase();
      drain();
      steady = 1'b0;

      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* button_click_discriminator_core.f */
rtl/bcd_pkg.sv
rtl/bcd_if.sv
rtl/bcd_in_stage.sv
rtl/bcd_click_fsm.sv
rtl/button_click_discriminator_core.sv
verif/tb_top.sv
